### rtl/mssb_pkg.sv
// ----------------------------------------------------------------------------
// mssb_pkg
// Shared types and constants for the merge-split sorted blocks unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mssb_pkg;

  localparam int BLOCK_DEPTH_DEF = 32;
  localparam int KEY_BITS_DEF    = 32;

  localparam int COORD_BITS = 32;
  localparam int TAG_BITS   = 32;
  localparam int POINT_BITS = 2 * COORD_BITS + TAG_BITS;
  localparam int COUNT_BITS = 6;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [1:0] REG_SORT_AXIS   = 2'd0;
  localparam logic [1:0] REG_KEEP_LOW    = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    logic                  sort_axis;
    logic                  keep_low;
    logic [COUNT_BITS-1:0] block_count;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/mssb_cfg_regs.sv
// ----------------------------------------------------------------------------
// mssb_cfg_regs
// APB register file holding the sort axis, the kept half and the block count.
// ----------------------------------------------------------------------------
`default_nettype none

module mssb_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mssb_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [mssb_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [mssb_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output mssb_pkg::cfg_t                           cfg
);
  import mssb_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sort_axis   <= 1'b0;
      cfg.keep_low    <= 1'b1;
      cfg.block_count <= BLOCK_COUNT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_SORT_AXIS:   cfg.sort_axis   <= pwdata[0];
        REG_KEEP_LOW:    cfg.keep_low    <= pwdata[0];
        REG_BLOCK_COUNT: cfg.block_count <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_SORT_AXIS:   prdata = APB_DATA_BITS'(cfg.sort_axis);
      REG_KEEP_LOW:    prdata = APB_DATA_BITS'(cfg.keep_low);
      REG_BLOCK_COUNT: prdata = APB_DATA_BITS'(cfg.block_count);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/mssb_core.sv
// ----------------------------------------------------------------------------
// mssb_core
// Point memory with two read ports, merge sequencer and result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mssb_core #(
  parameter int BLOCK_DEPTH = mssb_pkg::BLOCK_DEPTH_DEF,
  parameter int KEY_BITS    = mssb_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  mssb_pkg::cfg_t                         cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_partner,
  input  mssb_pkg::point_t                       in_point,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mssb_pkg::point_t                       out_point,
  output logic                                   out_last
);
  import mssb_pkg::*;

  localparam int CW  = $clog2(BLOCK_DEPTH + 1);
  localparam int IW  = CW + 1;
  localparam int AW  = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int PAW = $clog2(2 * BLOCK_DEPTH);

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_PRIME0 = 3'd1;
  localparam logic [2:0] ST_PRIME1 = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_EPRIME = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  point_t pt_mem  [0:2*BLOCK_DEPTH-1];
  point_t res_mem [0:BLOCK_DEPTH-1];

  logic [2:0]    state, state_next;
  logic [CW-1:0] own_fill, own_fill_next;
  logic [CW-1:0] peer_fill, peer_fill_next;
  logic [IW-1:0] own_idx, peer_idx, at_idx, emit_idx;
  point_t        head_own, head_peer, rd_own, rd_peer, res_rd;

  logic [6:0]    n_wide;
  logic [IW-1:0] n;
  logic [CW-1:0] n_c;

  logic          accept, own_wr, peer_wr, trigger;
  logic [IW-1:0] own_k, peer_k, emit_k;
  logic [PAW-1:0] own_raddr, peer_raddr, waddr;
  logic          take_own, own_lt, own_gt;
  logic signed [KEY_BITS-1:0] key_own, key_peer;
  logic [AW-1:0] wpos;
  point_t        merged;

  function automatic logic [AW-1:0] kaddr(input logic lo, input logic [IW-1:0] nn,
                                          input logic [IW-1:0] k);
    logic [IW-1:0] r;
    r = lo ? k : IW'(nn - k - IW'(1));
    return r[AW-1:0];
  endfunction

  always_comb begin
    if (cfg.block_count == '0) begin
      n_wide = 7'd1;
    end else if ({1'b0, cfg.block_count} > 7'(BLOCK_DEPTH)) begin
      n_wide = 7'(BLOCK_DEPTH);
    end else begin
      n_wide = {1'b0, cfg.block_count};
    end
  end
  assign n   = IW'(n_wide);
  assign n_c = n[CW-1:0];

  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid & in_ready;
  assign own_wr   = accept & ~in_partner & (own_fill < n_c);
  assign peer_wr  = accept & in_partner & (peer_fill < n_c);

  assign own_fill_next  = own_wr  ? CW'(own_fill + CW'(1))  : own_fill;
  assign peer_fill_next = peer_wr ? CW'(peer_fill + CW'(1)) : peer_fill;
  assign trigger = accept & (own_fill_next >= n_c) & (peer_fill_next >= n_c);

  always_comb begin
    if (own_wr) begin
      waddr = PAW'(own_fill[AW-1:0]);
    end else begin
      waddr = PAW'(BLOCK_DEPTH) + PAW'(peer_fill[AW-1:0]);
    end
  end

  assign key_own  = cfg.sort_axis ? head_own.y[KEY_BITS-1:0]  : head_own.x[KEY_BITS-1:0];
  assign key_peer = cfg.sort_axis ? head_peer.y[KEY_BITS-1:0] : head_peer.x[KEY_BITS-1:0];
  assign own_lt   = key_own < key_peer;
  assign own_gt   = key_own > key_peer;

  always_comb begin
    if (own_idx >= n) begin
      take_own = 1'b0;
    end else if (peer_idx >= n) begin
      take_own = 1'b1;
    end else begin
      take_own = cfg.keep_low ? own_lt : own_gt;
    end
  end

  assign merged = take_own ? head_own : head_peer;
  assign wpos   = kaddr(cfg.keep_low, n, at_idx);

  always_comb begin
    own_k  = '0;
    peer_k = '0;
    emit_k = '0;
    case (state)
      ST_PRIME1: begin
        own_k  = IW'(1);
        peer_k = IW'(1);
      end
      ST_MERGE: begin
        own_k  = take_own ? IW'(own_idx + IW'(2)) : IW'(own_idx + IW'(1));
        peer_k = take_own ? IW'(peer_idx + IW'(1)) : IW'(peer_idx + IW'(2));
      end
      ST_EMIT: begin
        emit_k = out_ready ? IW'(emit_idx + IW'(1)) : emit_idx;
      end
      default: ;
    endcase
  end

  assign own_raddr  = PAW'(kaddr(cfg.keep_low, n, own_k));
  assign peer_raddr = PAW'(BLOCK_DEPTH) + PAW'(kaddr(cfg.keep_low, n, peer_k));

  always_ff @(posedge clk) begin
    if (own_wr || peer_wr) begin
      pt_mem[waddr] <= in_point;
    end
    rd_own  <= pt_mem[own_raddr];
    rd_peer <= pt_mem[peer_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_MERGE) begin
      res_mem[wpos] <= merged;
    end
    res_rd <= res_mem[emit_k[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (trigger) state_next = ST_PRIME0;
      ST_PRIME0: state_next = ST_PRIME1;
      ST_PRIME1: state_next = ST_MERGE;
      ST_MERGE:  if (at_idx == IW'(n - IW'(1))) state_next = ST_EPRIME;
      ST_EPRIME: state_next = ST_EMIT;
      ST_EMIT:   if (out_ready && emit_idx == IW'(n - IW'(1))) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      own_fill  <= '0;
      peer_fill <= '0;
      own_idx   <= '0;
      peer_idx  <= '0;
      at_idx    <= '0;
      emit_idx  <= '0;
    end else begin
      state <= state_next;
      if (trigger) begin
        own_fill  <= '0;
        peer_fill <= '0;
      end else begin
        own_fill  <= own_fill_next;
        peer_fill <= peer_fill_next;
      end
      case (state)
        ST_PRIME1: begin
          own_idx  <= '0;
          peer_idx <= '0;
          at_idx   <= '0;
        end
        ST_MERGE: begin
          at_idx <= IW'(at_idx + IW'(1));
          if (take_own) begin
            own_idx <= IW'(own_idx + IW'(1));
          end else begin
            peer_idx <= IW'(peer_idx + IW'(1));
          end
        end
        ST_EPRIME: emit_idx <= '0;
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= IW'(emit_idx + IW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PRIME1) begin
      head_own  <= rd_own;
      head_peer <= rd_peer;
    end else if (state == ST_MERGE) begin
      if (take_own) begin
        head_own <= rd_own;
      end else begin
        head_peer <= rd_peer;
      end
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_point = res_rd;
  assign out_last  = (emit_idx == IW'(n - IW'(1)));

endmodule

`default_nettype wire

### rtl/merge_split_sorted_blocks_unit.sv
// ----------------------------------------------------------------------------
// merge_split_sorted_blocks_unit
// Compare-split step of a block sorting network over two sorted point blocks.
// ----------------------------------------------------------------------------
// Points arrive on the slave stream, one request per point; tuser marks a
// partner point. Each block holds N points, N being the block count register
// clamped to 1..BLOCK_DEPTH, and points for a full block are dropped. Points
// are loaded into a point memory with two read ports.
// When both blocks hold N points the unit stops taking points, primes the
// memory reads (PRIME0, PRIME1), then merges one point per cycle into a
// result buffer and primes the buffer read (EPRIME).
// The master stream then delivers N points in ascending order, one per cycle
// while it is ready, tlast on the final one. The priming states cover the
// registered point memory reads. A stalled master stream holds the current
// point and nothing is lost; no points are taken until the block has been
// delivered.
// Reset empties both blocks and restores the registers (x axis, low half,
// block count 32). Memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_split_sorted_blocks_unit #(
  parameter int BLOCK_DEPTH = mssb_pkg::BLOCK_DEPTH_DEF,
  parameter int KEY_BITS    = mssb_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mssb_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [mssb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [mssb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // key_x [31:0], key_y [63:32], tag [95:64]
  input  wire logic [mssb_pkg::POINT_BITS-1:0]    s_tdata,
  // from_partner [0]
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // out_x [31:0], out_y [63:32], out_tag [95:64]
  output logic      [mssb_pkg::POINT_BITS-1:0]    m_tdata,
  output logic                                    m_tlast
);
  import mssb_pkg::*;

  cfg_t   cfg;
  point_t in_point, out_point;

  assign in_point = point_t'(s_tdata);
  assign m_tdata  = POINT_BITS'(out_point);

  mssb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mssb_core #(
    .BLOCK_DEPTH (BLOCK_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_partner (s_tuser),
    .in_point   (in_point),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_point  (out_point),
    .out_last   (m_tlast)
  );

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("points taken while a block is being delivered");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("output still valid after the final point");

  a_block_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("block delivery broke off before the final point");

endmodule

`default_nettype wire

### tb/sv/merge_split_sorted_blocks_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_split_sorted_blocks_unit_test
// Self-checking bench for the merge-split sorted blocks unit.
// ----------------------------------------------------------------------------
// Own and partner blocks are streamed in with random interleaving, random
// gaps and extra points for blocks that are already full. The bench merges
// the blocks itself, keeping the lower or upper half on the chosen key, and
// compares every delivered point with the oldest expected one. Registers are
// rewritten between phases, covering counts of zero, one, small values, the
// block depth and above it.
// ----------------------------------------------------------------------------
module merge_split_sorted_blocks_unit_test;
  import mssb_pkg::*;

  localparam int DEPTH        = BLOCK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 330;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    point_t pt;
    bit     last;
  } out_point_t;

  class point_merger;
    point_t                own_pts[DEPTH];
    point_t                peer_pts[DEPTH];
    int                    own_fill;
    int                    peer_fill;
    bit                    sort_axis;
    bit                    keep_low;
    logic [COUNT_BITS-1:0] block_count;
    out_point_t            expected_points[$];
    int                    mismatches;
    int                    checked;
    int                    merges;
    int                    dropped;
    int                    accepted;

    function new();
      own_fill    = 0;
      peer_fill   = 0;
      sort_axis   = 1'b0;
      keep_low    = 1'b1;
      block_count = BLOCK_COUNT_RESET;
      mismatches  = 0;
      checked     = 0;
      merges      = 0;
      dropped     = 0;
      accepted    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SORT_AXIS:   sort_axis = val[0];
        REG_KEEP_LOW:    keep_low = val[0];
        REG_BLOCK_COUNT: block_count = val[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int count_now();
      if (block_count == 0) return 1;
      if (block_count > DEPTH) return DEPTH;
      return int'(block_count);
    endfunction

    function logic signed [COORD_BITS-1:0] key_of(point_t p);
      return sort_axis ? $signed(p.y) : $signed(p.x);
    endfunction

    function void merge_blocks(int n);
      point_t     merged[DEPTH];
      out_point_t item;
      int         i;
      int         j;
      bit         take_own;
      i = 0;
      j = 0;
      if (keep_low) begin
        for (int at = 0; at < n; at++) begin
          take_own = (i < n) && ((j >= n) || (key_of(own_pts[i]) < key_of(peer_pts[j])));
          if (take_own) begin
            merged[at] = own_pts[i];
            i++;
          end else begin
            merged[at] = peer_pts[j];
            j++;
          end
        end
      end else begin
        // The upper half is filled from the top down; ties go to the partner.
        for (int at = n; at > 0; at--) begin
          take_own = (i < n) && ((j >= n) ||
                     (key_of(own_pts[n-1-i]) > key_of(peer_pts[n-1-j])));
          if (take_own) begin
            merged[at-1] = own_pts[n-1-i];
            i++;
          end else begin
            merged[at-1] = peer_pts[n-1-j];
            j++;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        item.pt   = merged[k];
        item.last = (k == n - 1);
        expected_points.push_back(item);
      end
    endfunction

    function void note_point(bit partner, point_t p);
      int n;
      n = count_now();
      accepted++;
      if (partner) begin
        if (peer_fill < n) begin
          peer_pts[peer_fill] = p;
          peer_fill++;
        end else begin
          dropped++;
        end
      end else begin
        if (own_fill < n) begin
          own_pts[own_fill] = p;
          own_fill++;
        end else begin
          dropped++;
        end
      end
      if (own_fill >= n && peer_fill >= n) begin
        merge_blocks(n);
        own_fill  = 0;
        peer_fill = 0;
        merges++;
      end
    endfunction

    function void check_point(point_t got, bit last);
      out_point_t want;
      checked++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: x %h y %h tag %h last %0b",
                   checked, got.x, got.y, got.tag, last);
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.pt.x || got.y !== want.pt.y || got.tag !== want.pt.tag ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at result %0d: expected x %h y %h tag %h last %0b,",
                    " got x %h y %h tag %h last %0b"},
                   checked, want.pt.x, want.pt.y, want.pt.tag, want.last,
                   got.x, got.y, got.tag, last);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [POINT_BITS-1:0]    s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [POINT_BITS-1:0]    m_tdata;
  logic                     m_tlast;

  point_merger merger;
  bit          no_idle;
  int          points_sent;
  int          reg_writes;
  int          cycles;

  merge_split_sorted_blocks_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("merge_split_sorted_blocks_unit_test failed");
      $finish;
    end
  end

  function automatic point_t mk(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] t);
    point_t p;
    p.x   = x;
    p.y   = y;
    p.tag = t;
    return p;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    merger.write_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input bit axis, input bit low, input logic [5:0] count);
    apb_write(REG_SORT_AXIS, {31'd0, axis});
    apb_write(REG_KEEP_LOW, {31'd0, low});
    apb_write(REG_BLOCK_COUNT, {26'd0, count});
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (merger.expected_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_point(input bit partner, input point_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = p;
    s_tuser  = partner;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    merger.note_point(partner, p);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input bit axis);
    point_t own_q[$];
    point_t peer_q[$];
    int     keys[$];
    point_t p;
    bit     pick_own;
    for (int s = 0; s < 2; s++) begin
      keys.delete();
      case ($urandom_range(0, 2))
        0: for (int k = 0; k < n; k++) keys.push_back($urandom);
        1: for (int k = 0; k < n; k++) keys.push_back($urandom_range(0, 6) - 3);
        default: begin
          for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
              0: keys.push_back(32'h80000000);
              1: keys.push_back(32'h7fffffff);
              2: keys.push_back(0);
              default: keys.push_back(-1);
            endcase
          end
        end
      endcase
      // Most blocks are sorted as the network would deliver them.
      if ($urandom_range(0, 6) != 0) keys.sort();
      for (int k = 0; k < n; k++) begin
        p.x   = axis ? $urandom : keys[k];
        p.y   = axis ? keys[k] : $urandom;
        p.tag = $urandom;
        if (s == 0) own_q.push_back(p);
        else peer_q.push_back(p);
      end
    end
    while (own_q.size() + peer_q.size() != 0) begin
      // A point for a block that is already full is dropped by the unit.
      if ((own_q.size() == 0 || peer_q.size() == 0) && $urandom_range(0, 5) == 0)
        send_point(own_q.size() == 0 ? 1'b0 : 1'b1, mk($urandom, $urandom, $urandom));
      pick_own = (peer_q.size() == 0) || (own_q.size() != 0 && $urandom_range(0, 1) == 1);
      if (pick_own) send_point(1'b0, own_q.pop_front());
      else send_point(1'b1, peer_q.pop_front());
      points_sent++;
    end
  endtask

  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      merger.check_point(m_tdata, m_tlast);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int         phase;
    int         n;
    int         sets;
    bit         axis;
    bit         low;
    logic [5:0] count;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    no_idle     = 1'b0;
    points_sent = 0;
    reg_writes  = 0;
    merger      = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // Extreme keys, a tie won by the partner and a dropped extra own point.
    configure(1'b0, 1'b1, 6'd2);
    send_point(1'b0, mk(32'h80000000, 32'h7fffffff, 32'h00000000));
    send_point(1'b0, mk(32'h7fffffff, 32'h80000000, 32'hffffffff));
    send_point(1'b0, mk(32'h12345678, 32'h9abcdef0, 32'h55aa55aa));
    send_point(1'b1, mk(32'h80000000, 32'h00000000, 32'h00000001));
    send_point(1'b1, mk(32'h7fffffff, 32'h00000001, 32'h00000002));
    drain();

    // A count of zero behaves as one; a tie on y in the upper half.
    configure(1'b1, 1'b0, 6'd0);
    send_point(1'b0, mk(32'd1, 32'd5, 32'h0000000a));
    send_point(1'b0, mk(32'd3, 32'd7, 32'h0000000b));
    send_point(1'b1, mk(32'd2, 32'd5, 32'h0000000c));
    drain();

    // Partner block entirely below the own block, strictly interleaved.
    configure(1'b1, 1'b1, 6'd3);
    for (int k = 0; k < 3; k++) begin
      send_point(1'b1, mk($urandom, k - 3, 32'h100 + k));
      send_point(1'b0, mk($urandom, k + 1, 32'h200 + k));
    end
    drain();

    // Every key tied in the upper half.
    configure(1'b0, 1'b0, 6'd3);
    for (int k = 0; k < 3; k++) send_point(1'b0, mk(10 * (k + 1), $urandom, 32'h300 + k));
    for (int k = 0; k < 3; k++) send_point(1'b1, mk(10 * (k + 1), $urandom, 32'h400 + k));
    drain();

    points_sent = 0;
    phase = 0;
    while (points_sent < RANDOM_ITEMS) begin
      axis = $urandom_range(0, 1);
      low  = $urandom_range(0, 1);
      if (phase == 1) begin
        count = 6'd63;
        low   = 1'b0;
      end else if (phase == 4) begin
        count = 6'd32;
        low   = 1'b1;
      end else begin
        count = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 7));
      end
      configure(axis, low, count);
      n = merger.count_now();
      sets = $urandom_range(1, 4);
      for (int s = 0; s < sets && points_sent < RANDOM_ITEMS; s++) begin
        no_idle = ($urandom_range(0, 3) == 0);
        send_set(n, axis);
        if ($urandom_range(0, 2) == 0) drain();
      end
      no_idle = 1'b0;
      drain();
      phase++;
    end

    drain();
    repeat (3 * DEPTH + 8) @(posedge clk);
    $display("Run covered %0d accepted points (%0d dropped), %0d merges, %0d register writes.",
             merger.accepted, merger.dropped, merger.merges, reg_writes);
    $display("%0d results checked, %0d mismatches, %0d still expected.",
             merger.checked, merger.mismatches, merger.expected_points.size());
    if (merger.mismatches == 0 && merger.expected_points.size() == 0) begin
      $display("merge_split_sorted_blocks_unit_test passed");
    end else begin
      $display("merge_split_sorted_blocks_unit_test failed");
    end
    $finish;
  end
endmodule
